// ===== src/mrr_pkg.sv =====
// shared types, constants and helpers for the matrix ring rotate unit
// no dependencies
`default_nettype none
package mrr_pkg;

  localparam int CW          = 7;   // size register width, also ring coordinate width
  localparam int LW          = CW + 2;  // ring length and ring position width
  localparam int SW          = 16;  // rotation count width
  localparam int VW          = 32;  // element width
  localparam int MOD_BITS    = 4;   // rotation count bits retired per remainder stage
  localparam int MOD_STAGES  = SW / MOD_BITS;
  localparam int MAX_DIM_DEF = 64;
  localparam int IDXW        = 2;   // register index width

  localparam logic [IDXW-1:0] REG_ROWS  = 2'd0;
  localparam logic [IDXW-1:0] REG_COLS  = 2'd1;
  localparam logic [IDXW-1:0] REG_STEPS = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic          vld;
    logic          cmd;
    logic          oor;
    logic          ring;
    logic [CW-1:0] r;
    logic [CW-1:0] c;
    logic [CW-1:0] k;
    logic [CW-1:0] h;
    logic [CW-1:0] w;
    logic [CW-1:0] i;
    logic [CW-1:0] j;
    logic [LW-1:0] len;
    logic [LW-1:0] p;
    logic [LW-1:0] rem;
    logic [VW-1:0] value;
  } item_t;

  typedef struct packed {
    logic vld;
    logic cmd;
    logic oor;
    logic wr_ok;
  } acc_ctl_t;

  // restoring remainder over a few dividend bits, msb first
  function automatic logic [LW-1:0] mod_step(input logic [LW-1:0] rem_in,
                                             input logic [MOD_BITS-1:0] bits,
                                             input logic [LW-1:0] div);
    logic [LW:0]   t;
    logic [LW-1:0] rr;
    rr = rem_in;
    for (int b = MOD_BITS - 1; b >= 0; b--) begin
      t = {rr, bits[b]};
      if (t >= {1'b0, div}) t = t - {1'b0, div};
      rr = t[LW-1:0];
    end
    return rr;
  endfunction

endpackage
`default_nettype wire

// ===== src/matrix_ring_rotate_unit.sv =====
// top level of the matrix ring rotate unit: configuration registers, remap pipeline, store
// depends on mrr_pkg, mrr_addr_pipe, mrr_store
`default_nettype none
// Holds a matrix of up to MAX_DIM by MAX_DIM signed 32-bit elements and reads it back
// with every concentric ring rotated counterclockwise by rotate_steps. A write word
// (command 0) stores an original element and returns nothing; a read word (command 1)
// returns the rotated element, or zero with out_of_range set outside the configured size.
// One word is accepted every clock while the output is taken; a read passes through
// the remap pipeline registers in order: bounds and ring index, ring
// size, four remainder stages that retire four bits of rotate_steps each, position add,
// source coordinate, address, then the single-port memory read. A stalled output holds
// the whole pipeline. Memory contents are undefined until written; no clearing pass.
module matrix_ring_rotate_unit #(
  parameter int MAX_DIM = mrr_pkg::MAX_DIM_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [mrr_pkg::IDXW-1:0] cfg_index,
  input  wire logic [mrr_pkg::SW-1:0]   cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     command,
  input  wire logic [5:0]               row,
  input  wire logic [5:0]               col,
  input  wire logic signed [31:0]       value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [31:0]            value_res,
  output logic                          out_of_range
);
  import mrr_pkg::*;

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  logic [CW-1:0] row_count, col_count, nr, nc;
  logic [SW-1:0] rotate_steps;
  logic          adv, res_oor;
  logic [VW-1:0] res_data;
  acc_ctl_t      acc_ctl;
  logic [AW-1:0] acc_addr;
  logic [VW-1:0] acc_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CW'(64);
      col_count    <= CW'(64);
      rotate_steps <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS:  row_count    <= cfg_data[CW-1:0];
        REG_COLS:  col_count    <= cfg_data[CW-1:0];
        REG_STEPS: rotate_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, above the store acts as the store size
  always_comb begin
    nr = row_count;
    nc = col_count;
    if (row_count == '0) nr = CW'(1);
    else if (32'(row_count) > MAX_DIM) nr = CW'(MAX_DIM);
    if (col_count == '0) nc = CW'(1);
    else if (32'(col_count) > MAX_DIM) nc = CW'(MAX_DIM);
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  mrr_addr_pipe #(.MAX_DIM(MAX_DIM), .AW(AW)) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .command  (command),
    .row      (row),
    .col      (col),
    .value    (value),
    .nr       (nr),
    .nc       (nc),
    .steps    (rotate_steps),
    .acc_ctl  (acc_ctl),
    .acc_addr (acc_addr),
    .acc_data (acc_data)
  );

  mrr_store #(.MAX_DIM(MAX_DIM), .AW(AW)) u_store (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .acc_ctl   (acc_ctl),
    .acc_addr  (acc_addr),
    .acc_data  (acc_data),
    .res_valid (out_valid),
    .res_oor   (res_oor),
    .res_data  (res_data)
  );

  assign out_of_range = res_oor;
  assign value_res    = res_oor ? '0 : res_data;

endmodule
`default_nettype wire

// ===== src/mrr_addr_pipe.sv =====
// address remap pipeline: ring index, ring position, rotation remainder, source address
// depends on mrr_pkg
`default_nettype none
module mrr_addr_pipe #(
  parameter int MAX_DIM = mrr_pkg::MAX_DIM_DEF,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     adv,
  input  wire logic                     in_valid,
  input  wire logic                     command,
  input  wire logic [5:0]               row,
  input  wire logic [5:0]               col,
  input  wire logic [mrr_pkg::VW-1:0]   value,
  input  wire logic [mrr_pkg::CW-1:0]   nr,
  input  wire logic [mrr_pkg::CW-1:0]   nc,
  input  wire logic [mrr_pkg::SW-1:0]   steps,
  output mrr_pkg::acc_ctl_t             acc_ctl,
  output logic [AW-1:0]                 acc_addr,
  output logic [mrr_pkg::VW-1:0]        acc_data
);
  import mrr_pkg::*;

  item_t s1, s2, sq, sm8;
  item_t sm [MOD_STAGES];
  item_t n1, n2, nq, n8;
  item_t nm [MOD_STAGES];

  // stage 1: bounds and ring index
  always_comb begin
    logic [CW-1:0] dr, dc, m1, m2;
    n1       = '0;
    n1.vld   = in_valid;
    n1.cmd   = command;
    n1.r     = {1'b0, row};
    n1.c     = {1'b0, col};
    n1.value = value;
    n1.oor   = (n1.r >= nr) || (n1.c >= nc);
    dr = nr - CW'(1) - n1.r;
    dc = nc - CW'(1) - n1.c;
    m1 = (n1.r < n1.c) ? n1.r : n1.c;
    m2 = (dr < dc) ? dr : dc;
    n1.k = n1.oor ? '0 : ((m1 < m2) ? m1 : m2);
  end

  // stage 2: ring size and local coordinates
  always_comb begin
    n2      = s1;
    n2.h    = nr - {s1.k[CW-2:0], 1'b0};
    n2.w    = nc - {s1.k[CW-2:0], 1'b0};
    n2.i    = s1.r - s1.k;
    n2.j    = s1.c - s1.k;
    n2.ring = (s1.cmd == CMD_READ) && !s1.oor && (n2.h >= CW'(2)) && (n2.w >= CW'(2));
    n2.len  = n2.ring ? ((LW'(n2.w) + LW'(n2.h) - LW'(2)) << 1) : LW'(1);
  end

  // remainder stages; the first also finds the clockwise position
  always_comb begin
    logic [LW-1:0] wm, hm, il, jl;
    wm = LW'(s2.w) - LW'(1);
    hm = LW'(s2.h) - LW'(1);
    il = LW'(s2.i);
    jl = LW'(s2.j);
    nm[0] = s2;
    if (!s2.ring) nm[0].p = '0;
    else if (il == '0) nm[0].p = jl;
    else if (jl == wm) nm[0].p = wm + il;
    else if (il == hm) nm[0].p = wm + hm + (wm - jl);
    else nm[0].p = (wm << 1) + hm + (hm - il);
    nm[0].rem = mod_step('0, steps[SW-1 -: MOD_BITS], s2.len);
    for (int s = 1; s < MOD_STAGES; s++) begin
      nm[s]     = sm[s-1];
      nm[s].rem = mod_step(sm[s-1].rem, steps[SW-1-s*MOD_BITS -: MOD_BITS], sm[s-1].len);
    end
  end

  // rotated position
  always_comb begin
    logic [LW:0] q;
    nq = sm[MOD_STAGES-1];
    q  = {1'b0, nq.p} + {1'b0, nq.rem};
    if (q >= {1'b0, nq.len}) q = q - {1'b0, nq.len};
    nq.p = q[LW-1:0];
  end

  // back to source row and column
  always_comb begin
    logic [LW-1:0] wm, hm, q, ii, jj;
    n8 = sq;
    wm = LW'(sq.w) - LW'(1);
    hm = LW'(sq.h) - LW'(1);
    q  = sq.p;
    if (q < wm) begin
      ii = '0;
      jj = q;
    end else if (q < wm + hm) begin
      ii = q - wm;
      jj = wm;
    end else if (q < (wm << 1) + hm) begin
      ii = hm;
      jj = wm - (q - wm - hm);
    end else begin
      ii = hm - (q - (wm << 1) - hm);
      jj = '0;
    end
    if (sq.cmd == CMD_READ && sq.oor) begin
      n8.r = '0;
      n8.c = '0;
    end else if (sq.ring) begin
      n8.r = CW'(ii) + sq.k;
      n8.c = CW'(jj) + sq.k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld      <= 1'b0;
      s2.vld      <= 1'b0;
      sq.vld      <= 1'b0;
      sm8.vld     <= 1'b0;
      for (int s = 0; s < MOD_STAGES; s++) sm[s].vld <= 1'b0;
      acc_ctl.vld <= 1'b0;
    end else if (adv) begin
      s1  <= n1;
      s2  <= n2;
      sq  <= nq;
      sm8 <= n8;
      for (int s = 0; s < MOD_STAGES; s++) sm[s] <= nm[s];
      acc_ctl.vld   <= sm8.vld;
      acc_ctl.cmd   <= sm8.cmd;
      acc_ctl.oor   <= sm8.oor;
      acc_ctl.wr_ok <= (32'(sm8.r) < MAX_DIM) && (32'(sm8.c) < MAX_DIM);
      acc_addr      <= AW'(32'(sm8.r) * MAX_DIM + 32'(sm8.c));
      acc_data      <= sm8.value;
    end
  end

endmodule
`default_nettype wire

// ===== src/mrr_store.sv =====
// element memory with registered read and the output word register
// depends on mrr_pkg
`default_nettype none
module mrr_store #(
  parameter int MAX_DIM = mrr_pkg::MAX_DIM_DEF,
  parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   adv,
  input  wire mrr_pkg::acc_ctl_t      acc_ctl,
  input  wire logic [AW-1:0]          acc_addr,
  input  wire logic [mrr_pkg::VW-1:0] acc_data,
  output logic                        res_valid,
  output logic                        res_oor,
  output logic [mrr_pkg::VW-1:0]      res_data
);
  import mrr_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc_ctl.vld && acc_ctl.cmd == CMD_WRITE && acc_ctl.wr_ok) mem[acc_addr] <= acc_data;
      res_data <= mem[acc_addr];
      res_oor  <= acc_ctl.oor;
    end
  end

  // writes give no word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= acc_ctl.vld && (acc_ctl.cmd == CMD_READ);
    end
  end

endmodule
`default_nettype wire

// ===== src/mrr_checker.sv =====
// port-level checks for the matrix ring rotate unit, bound to the top level
// depends on matrix_ring_rotate_unit
`default_nettype none
module mrr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] value_res,
  input wire logic        out_of_range
);

  // the pipeline only moves when the output can drain
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output drain");

  a_no_word_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("word presented right after reset");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (value_res == 32'd0))
    else $error("out of range word carries a value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(value_res) && $stable(out_of_range)))
    else $error("stalled word changed");

endmodule

bind matrix_ring_rotate_unit mrr_checker u_mrr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .value_res    (value_res),
  .out_of_range (out_of_range)
);
`default_nettype wire
